/* src/fic_pkg.sv */
`timescale 1ns / 1ps

package fic_pkg;

    // width of the running file offset
    localparam int OFFSET_BITS = 24;
    // width of the reported image offset
    localparam int IMAGE_OFFSET_W = 24;
    localparam int FC_W = 6;

    localparam logic [7:0] START_BYTE = 8'hE9;
    localparam logic [7:0] SEED = 8'hEF;

    localparam logic [FC_W-1:0] HDR_LEN = 6'd24;
    localparam logic [FC_W-1:0] FLAG_IDX = 6'd23;
    localparam logic [FC_W-1:0] COUNT_IDX = 6'd1;
    localparam logic [FC_W-1:0] SEGHDR_LEN = 6'd8;
    localparam logic [FC_W-1:0] HASH_LEN = 6'd32;
    localparam logic [FC_W-1:0] SIZE_IDX0 = 6'd4;
    localparam logic [FC_W-1:0] SIZE_IDX1 = 6'd5;
    localparam logic [FC_W-1:0] SIZE_IDX2 = 6'd6;
    localparam logic [FC_W-1:0] SIZE_IDX3 = 6'd7;

    typedef enum logic [2:0] {
        PH_SCAN   = 3'd0,
        PH_HDR    = 3'd1,
        PH_SEGHDR = 3'd2,
        PH_DATA   = 3'd3,
        PH_PAD    = 3'd4,
        PH_HASH   = 3'd5
    } phase_t;

    // input register contents handed to the parser
    typedef struct packed {
        logic       valid;
        logic [7:0] data_byte;
        logic       last_byte;
    } beat_t;

    typedef struct packed {
        logic [7:0]                out_byte;
        logic                      report_valid;
        logic [IMAGE_OFFSET_W-1:0] image_offset;
        logic [7:0]                computed_checksum;
        logic [7:0]                stored_checksum;
        logic                      checksum_mismatch;
        logic                      hash_was_present;
        logic                      truncated_error;
        logic                      last;
    } result_t;

endpackage

/* src/fic_byte_if.sv */
`timescale 1ns / 1ps

interface fic_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, data_byte, last_byte, input ready);
    modport sink (input valid, data_byte, last_byte, output ready);
endinterface

/* src/fic_result_if.sv */
`timescale 1ns / 1ps

interface fic_result_if;
    logic                               valid;
    logic                               ready;
    logic [7:0]                         out_byte;
    logic                               report_valid;
    logic [fic_pkg::IMAGE_OFFSET_W-1:0] image_offset;
    logic [7:0]                         computed_checksum;
    logic [7:0]                         stored_checksum;
    logic                               checksum_mismatch;
    logic                               hash_was_present;
    logic                               truncated_error;
    logic                               last;

    modport source (
        output valid, out_byte, report_valid, image_offset, computed_checksum,
               stored_checksum, checksum_mismatch, hash_was_present,
               truncated_error, last,
        input  ready
    );
    modport sink (
        input  valid, out_byte, report_valid, image_offset, computed_checksum,
               stored_checksum, checksum_mismatch, hash_was_present,
               truncated_error, last,
        output ready
    );
endinterface

/* src/fic_in_stage.sv */
`timescale 1ns / 1ps

module fic_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    fic_byte_if.sink            in_ch,
    input  logic                advance,
    output fic_pkg::beat_t      beat
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       last_reg;
    logic       load;

    // a new beat may enter when the register is empty or moves on this cycle
    assign in_ch.ready = !valid_reg || advance;
    assign load = in_ch.valid && in_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= in_ch.data_byte;
            last_reg <= in_ch.last_byte;
        end
    end

    assign beat.valid     = valid_reg;
    assign beat.data_byte = data_reg;
    assign beat.last_byte = last_reg;

endmodule

/* src/fic_parser.sv */
`timescale 1ns / 1ps

module fic_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write_en,
    input  logic             cfg_write_data,
    input  fic_pkg::beat_t   beat,
    output logic             advance,
    fic_result_if.source     out_ch
);

    logic                             rewrite_reg;
    fic_pkg::phase_t                  phase_reg, phase_next;
    logic [fic_pkg::OFFSET_BITS-1:0]  position_reg, position_next;
    logic [fic_pkg::FC_W-1:0]         fc_reg, fc_next;
    logic [7:0]                       seg_left_reg, seg_left_next;
    logic [31:0]                      size_left_reg, size_left_next;
    logic [7:0]                       acc_reg, acc_next;
    logic                             hash_reg, hash_next;
    logic [fic_pkg::OFFSET_BITS-1:0]  start_reg, start_next;
    logic                             out_valid_reg, out_valid_next;
    fic_pkg::result_t                 result_reg, result_next;

    logic [fic_pkg::FC_W-1:0]         fc_inc;
    logic [7:0]                       seg_dec;
    logic [7:0]                       b;
    logic                             rep;
    logic                             trunc;
    logic [7:0]                       stored;
    logic                             fire;

    assign advance = !out_valid_reg || out_ch.ready;
    assign fire = beat.valid && advance;
    assign b = beat.data_byte;
    assign fc_inc = fc_reg + 1'b1;
    assign seg_dec = seg_left_reg - 1'b1;

    // parse step for one byte
    always_comb
    begin
        phase_next     = phase_reg;
        position_next  = position_reg;
        fc_next        = fc_reg;
        seg_left_next  = seg_left_reg;
        size_left_next = size_left_reg;
        acc_next       = acc_reg;
        hash_next      = hash_reg;
        start_next     = start_reg;
        rep            = 1'b0;
        trunc          = 1'b0;
        stored         = 8'd0;
        result_next    = '0;
        result_next.out_byte = b;

        unique case (phase_reg)
            fic_pkg::PH_HDR:
            begin
                if (fc_reg == fic_pkg::COUNT_IDX)
                begin
                    seg_left_next = b;
                end
                if (fc_reg == fic_pkg::FLAG_IDX)
                begin
                    hash_next = (b != 8'd0);
                    if (rewrite_reg)
                    begin
                        result_next.out_byte = 8'd0;
                    end
                end
                if (fc_inc >= fic_pkg::HDR_LEN)
                begin
                    fc_next = '0;
                    phase_next = (seg_left_next != 8'd0) ? fic_pkg::PH_SEGHDR
                                                         : fic_pkg::PH_PAD;
                end
                else
                begin
                    fc_next = fc_inc;
                end
            end
            fic_pkg::PH_SEGHDR:
            begin
                // little-endian size in header bytes four to seven
                unique case (fc_reg)
                    fic_pkg::SIZE_IDX0: size_left_next = {24'd0, b};
                    fic_pkg::SIZE_IDX1: size_left_next = size_left_reg | {16'd0, b, 8'd0};
                    fic_pkg::SIZE_IDX2: size_left_next = size_left_reg | {8'd0, b, 16'd0};
                    fic_pkg::SIZE_IDX3: size_left_next = size_left_reg | {b, 24'd0};
                    default:            size_left_next = size_left_reg;
                endcase
                if (fc_inc >= fic_pkg::SEGHDR_LEN)
                begin
                    fc_next = '0;
                    if (size_left_next == 32'd0)
                    begin
                        seg_left_next = seg_dec;
                        phase_next = (seg_dec != 8'd0) ? fic_pkg::PH_SEGHDR
                                                       : fic_pkg::PH_PAD;
                    end
                    else
                    begin
                        phase_next = fic_pkg::PH_DATA;
                    end
                end
                else
                begin
                    fc_next = fc_inc;
                end
            end
            fic_pkg::PH_DATA:
            begin
                acc_next = acc_reg ^ b;
                size_left_next = size_left_reg - 32'd1;
                if (size_left_next == 32'd0)
                begin
                    seg_left_next = seg_dec;
                    fc_next = '0;
                    phase_next = (seg_dec != 8'd0) ? fic_pkg::PH_SEGHDR
                                                   : fic_pkg::PH_PAD;
                end
            end
            fic_pkg::PH_PAD:
            begin
                // checksum byte sits at offset 15 mod 16
                if (position_reg[3:0] == 4'hF)
                begin
                    rep = 1'b1;
                    stored = b;
                    if (rewrite_reg)
                    begin
                        result_next.out_byte = acc_reg;
                    end
                    fc_next = '0;
                    phase_next = hash_reg ? fic_pkg::PH_HASH : fic_pkg::PH_SCAN;
                end
            end
            fic_pkg::PH_HASH:
            begin
                if (fc_inc >= fic_pkg::HASH_LEN)
                begin
                    fc_next = '0;
                    phase_next = fic_pkg::PH_SCAN;
                end
                else
                begin
                    fc_next = fc_inc;
                end
            end
            default:
            begin
                phase_next = fic_pkg::PH_SCAN;
                if (position_reg[3:0] == 4'h0 && b == fic_pkg::START_BYTE)
                begin
                    start_next = position_reg;
                    acc_next = fic_pkg::SEED;
                    hash_next = 1'b0;
                    seg_left_next = 8'd0;
                    size_left_next = 32'd0;
                    fc_next = fic_pkg::COUNT_IDX;
                    phase_next = fic_pkg::PH_HDR;
                end
            end
        endcase

        // file ends inside an image before its checksum byte
        if (beat.last_byte && !rep &&
            (phase_next == fic_pkg::PH_HDR || phase_next == fic_pkg::PH_SEGHDR ||
             phase_next == fic_pkg::PH_DATA || phase_next == fic_pkg::PH_PAD))
        begin
            rep = 1'b1;
            trunc = 1'b1;
            stored = 8'd0;
        end

        result_next.report_valid = rep;
        result_next.last = beat.last_byte;
        result_next.truncated_error = trunc;
        if (rep)
        begin
            result_next.image_offset = fic_pkg::IMAGE_OFFSET_W'(start_next);
            result_next.computed_checksum = acc_next;
            result_next.stored_checksum = stored;
            result_next.checksum_mismatch = !trunc && (stored != acc_next);
            result_next.hash_was_present = hash_next;
        end

        // end of file returns everything to the start-of-file state
        if (beat.last_byte)
        begin
            phase_next     = fic_pkg::PH_SCAN;
            position_next  = '0;
            fc_next        = '0;
            seg_left_next  = 8'd0;
            size_left_next = 32'd0;
            acc_next       = fic_pkg::SEED;
            hash_next      = 1'b0;
            start_next     = '0;
        end
        else
        begin
            position_next = position_reg + 1'b1;
        end
    end

    // output valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // parser state and config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rewrite_reg   <= 1'b0;
            phase_reg     <= fic_pkg::PH_SCAN;
            position_reg  <= '0;
            fc_reg        <= '0;
            seg_left_reg  <= 8'd0;
            size_left_reg <= 32'd0;
            acc_reg       <= fic_pkg::SEED;
            hash_reg      <= 1'b0;
            start_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
            begin
                rewrite_reg <= cfg_write_data;
            end
            if (fire)
            begin
                phase_reg     <= phase_next;
                position_reg  <= position_next;
                fc_reg        <= fc_next;
                seg_left_reg  <= seg_left_next;
                size_left_reg <= size_left_next;
                acc_reg       <= acc_next;
                hash_reg      <= hash_next;
                start_reg     <= start_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= result_next;
        end
    end

    assign out_ch.valid             = out_valid_reg;
    assign out_ch.out_byte          = result_reg.out_byte;
    assign out_ch.report_valid      = result_reg.report_valid;
    assign out_ch.image_offset      = result_reg.image_offset;
    assign out_ch.computed_checksum = result_reg.computed_checksum;
    assign out_ch.stored_checksum   = result_reg.stored_checksum;
    assign out_ch.checksum_mismatch = result_reg.checksum_mismatch;
    assign out_ch.hash_was_present  = result_reg.hash_was_present;
    assign out_ch.truncated_error   = result_reg.truncated_error;
    assign out_ch.last              = result_reg.last;

endmodule

/* src/firmware_image_checksum_fixer_unit.sv */
// Firmware image checksum fixer: streams a firmware file byte by byte.
// file_bytes carries one file byte per beat (data_byte, last_byte marks the
// final byte of the file). results returns exactly one beat per input beat:
// the byte passed through, or rewritten when rewrite mode is on, plus an
// image report on the checksum byte or on a file that ends mid-image.
// cfg_write_en / cfg_write_data set rewrite mode; write only while idle.
// A byte accepted into the input register passes through the parser logic
// into the result register, from which it is presented on results.
// Throughput: one byte per cycle while results does not stall; each byte
// costs one pass through the parser logic between the two registers.
// When results stalls, the result register holds and the input register
// still takes one more byte; file_bytes.ready drops once both are full.
// Reset (rst_n low, asynchronous) empties both registers, clears rewrite
// mode and returns the parser to scanning at file offset zero. A last_byte
// beat also returns the parser to that state for the next file.
`timescale 1ns / 1ps

module firmware_image_checksum_fixer_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_write_en,
    input  logic          cfg_write_data,
    fic_byte_if.sink      file_bytes,
    fic_result_if.source  results
);

    fic_pkg::beat_t beat;
    logic           advance;

    // input register
    fic_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (file_bytes),
        .advance (advance),
        .beat    (beat)
    );

    // parser and result register
    fic_parser u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .beat           (beat),
        .advance        (advance),
        .out_ch         (results)
    );

endmodule

/* test/tb_firmware_image_checksum_fixer_unit.sv */
`timescale 1ns / 1ps

module tb_firmware_image_checksum_fixer_unit;

    import fic_pkg::*;

    localparam int TARGET_BYTES = 1400;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_REPORTS  = 10;

    // tracks the image parser state and the result beats still owed by the block
    class checksum_tracker;
        result_t                 pending_beats[$];
        bit                      rewrite_on;
        int                      bad_beats;
        int                      beat_index;
        phase_t                  ph;
        logic [OFFSET_BITS-1:0]  file_pos;
        logic [FC_W-1:0]         fcnt;
        logic [7:0]              segs_left;
        logic [31:0]             seg_bytes_left;
        logic [7:0]              xor_acc;
        logic                    hash_seen;
        logic [OFFSET_BITS-1:0]  img_start;

        function new();
            rewrite_on = 1'b0;
            bad_beats  = 0;
            beat_index = 0;
            clear_parser();
        endfunction

        function void clear_parser();
            ph             = PH_SCAN;
            file_pos       = '0;
            fcnt           = '0;
            segs_left      = '0;
            seg_bytes_left = '0;
            xor_acc        = SEED;
            hash_seen      = 1'b0;
            img_start      = '0;
        endfunction

        function void close_segment();
            segs_left = segs_left - 8'd1;
            fcnt      = '0;
            if (segs_left != 8'd0)
                ph = PH_SEGHDR;
            else
                ph = PH_PAD;
        endfunction

        // work out the result beat for one accepted file byte
        function void take_byte(logic [7:0] b, logic lastf);
            result_t          want;
            logic [FC_W-1:0]  nf;
            logic [7:0]       ob;
            logic [7:0]       stored;
            logic             rep;
            logic             trunc;
            logic             mism;

            ob     = b;
            rep    = 1'b0;
            trunc  = 1'b0;
            stored = 8'h00;
            mism   = 1'b0;

            case (ph)
                PH_HDR:
                begin
                    if (fcnt == COUNT_IDX)
                        segs_left = b;
                    if (fcnt == FLAG_IDX)
                    begin
                        hash_seen = (b != 8'h00);
                        if (rewrite_on)
                            ob = 8'h00;
                    end
                    nf = fcnt + 1'b1;
                    if (nf >= HDR_LEN)
                    begin
                        fcnt = '0;
                        if (segs_left != 8'd0)
                            ph = PH_SEGHDR;
                        else
                            ph = PH_PAD;
                    end
                    else
                        fcnt = nf;
                end
                PH_SEGHDR:
                begin
                    if (fcnt == SIZE_IDX0)
                        seg_bytes_left = 32'(b);
                    else if (fcnt > SIZE_IDX0 && fcnt < SEGHDR_LEN)
                        seg_bytes_left = seg_bytes_left
                                         | (32'(b) << (8 * (fcnt - SIZE_IDX0)));
                    nf = fcnt + 1'b1;
                    if (nf >= SEGHDR_LEN)
                    begin
                        fcnt = '0;
                        if (seg_bytes_left == 32'd0)
                            close_segment();
                        else
                            ph = PH_DATA;
                    end
                    else
                        fcnt = nf;
                end
                PH_DATA:
                begin
                    xor_acc        = xor_acc ^ b;
                    seg_bytes_left = seg_bytes_left - 32'd1;
                    if (seg_bytes_left == 32'd0)
                        close_segment();
                end
                PH_PAD:
                begin
                    // checksum byte sits on the next offset that is 15 mod 16
                    if (file_pos[3:0] == 4'hF)
                    begin
                        rep    = 1'b1;
                        stored = b;
                        mism   = (b != xor_acc);
                        if (rewrite_on)
                            ob = xor_acc;
                        fcnt = '0;
                        if (hash_seen)
                            ph = PH_HASH;
                        else
                            ph = PH_SCAN;
                    end
                end
                PH_HASH:
                begin
                    nf = fcnt + 1'b1;
                    if (nf >= HASH_LEN)
                    begin
                        fcnt = '0;
                        ph   = PH_SCAN;
                    end
                    else
                        fcnt = nf;
                end
                default:
                begin
                    ph = PH_SCAN;
                    if (file_pos[3:0] == 4'h0 && b == START_BYTE)
                    begin
                        img_start      = file_pos;
                        xor_acc        = SEED;
                        hash_seen      = 1'b0;
                        segs_left      = '0;
                        seg_bytes_left = '0;
                        fcnt           = 6'd1;
                        ph             = PH_HDR;
                    end
                end
            endcase

            // file ended inside an image before its checksum byte
            if (lastf && !rep && ph >= PH_HDR && ph <= PH_PAD)
            begin
                rep    = 1'b1;
                trunc  = 1'b1;
                stored = 8'h00;
                mism   = 1'b0;
            end

            want.out_byte          = ob;
            want.report_valid      = rep;
            want.image_offset      = rep ? img_start[IMAGE_OFFSET_W-1:0] : '0;
            want.computed_checksum = rep ? xor_acc : 8'h00;
            want.stored_checksum   = rep ? stored : 8'h00;
            want.checksum_mismatch = rep ? mism : 1'b0;
            want.hash_was_present  = rep ? hash_seen : 1'b0;
            want.truncated_error   = trunc;
            want.last              = lastf;
            pending_beats.push_back(want);

            if (lastf)
                clear_parser();
            else
                file_pos = file_pos + 1'b1;
        endfunction

        // compare one result beat against the oldest owed beat
        function void match_beat(result_t got);
            result_t want;
            bit      differs;

            beat_index++;
            if (pending_beats.size() == 0)
            begin
                bad_beats++;
                if (bad_beats <= MAX_REPORTS)
                    $display("result beat %0d arrived with nothing owed", beat_index);
                return;
            end
            want    = pending_beats.pop_front();
            differs = (got.out_byte          !== want.out_byte)
                   || (got.report_valid      !== want.report_valid)
                   || (got.image_offset      !== want.image_offset)
                   || (got.computed_checksum !== want.computed_checksum)
                   || (got.stored_checksum   !== want.stored_checksum)
                   || (got.checksum_mismatch !== want.checksum_mismatch)
                   || (got.hash_was_present  !== want.hash_was_present)
                   || (got.truncated_error   !== want.truncated_error)
                   || (got.last              !== want.last);
            if (differs)
            begin
                bad_beats++;
                if (bad_beats <= MAX_REPORTS)
                begin
                    $display("result beat %0d differs (byte rep off comp stored mm hash trunc last)",
                             beat_index);
                    $display("  expected %h %b %h %h %h %b %b %b %b", want.out_byte,
                             want.report_valid, want.image_offset, want.computed_checksum,
                             want.stored_checksum, want.checksum_mismatch,
                             want.hash_was_present, want.truncated_error, want.last);
                    $display("  actual   %h %b %h %h %h %b %b %b %b", got.out_byte,
                             got.report_valid, got.image_offset, got.computed_checksum,
                             got.stored_checksum, got.checksum_mismatch,
                             got.hash_was_present, got.truncated_error, got.last);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_write_en;
    logic cfg_write_data;

    fic_byte_if   bytes_ch ();
    fic_result_if results_ch ();

    checksum_tracker tracker;
    result_t         seen_beat;
    logic [7:0]      file_buf[$];
    int              bytes_sent;
    int              burst_left;
    int              cycles;

    firmware_image_checksum_fixer_unit u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .file_bytes     (bytes_ch),
        .results        (results_ch)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result monitor: sample each accepted beat at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && results_ch.valid && results_ch.ready)
        begin
            seen_beat.out_byte          = results_ch.out_byte;
            seen_beat.report_valid      = results_ch.report_valid;
            seen_beat.image_offset      = results_ch.image_offset;
            seen_beat.computed_checksum = results_ch.computed_checksum;
            seen_beat.stored_checksum   = results_ch.stored_checksum;
            seen_beat.checksum_mismatch = results_ch.checksum_mismatch;
            seen_beat.hash_was_present  = results_ch.hash_was_present;
            seen_beat.truncated_error   = results_ch.truncated_error;
            seen_beat.last              = results_ch.last;
            tracker.match_beat(seen_beat);
        end
    end

    // receiver backpressure: a new random stall style is picked at the end of each span
    initial
    begin
        int   stall_style;
        int   span;
        int   stall_left;
        int   tick;
        logic rdy;

        results_ch.ready = 1'b0;
        span       = 0;
        stall_left = 0;
        tick       = 0;
        stall_style = 0;
        forever
        begin
            @(negedge clk);
            if (span == 0)
            begin
                stall_style = $urandom_range(0, 3);
                span        = $urandom_range(20, 80);
            end
            span--;
            tick++;
            case (stall_style)
                0: rdy = 1'b1;
                1: rdy = ($urandom_range(0, 3) != 0);
                2: rdy = ((tick % 4) != 3);
                default:
                begin
                    if (stall_left > 0)
                    begin
                        stall_left--;
                        rdy = 1'b0;
                    end
                    else if ($urandom_range(0, 15) == 0)
                    begin
                        stall_left = $urandom_range(4, 16);
                        rdy        = 1'b0;
                    end
                    else
                        rdy = 1'b1;
                end
            endcase
            results_ch.ready <= rdy;
        end
    end

    // present one file byte, sender idles between bursts
    task automatic send_byte(input logic [7:0] b, input logic lastf);
        if (burst_left == 0)
        begin
            bytes_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            if ($urandom_range(0, 4) == 0)
                burst_left = $urandom_range(60, 160);
            else
                burst_left = $urandom_range(1, 20);
        end
        bytes_ch.valid     <= 1'b1;
        bytes_ch.data_byte <= b;
        bytes_ch.last_byte <= lastf;
        @(posedge clk);
        while (!bytes_ch.ready)
            @(posedge clk);
        tracker.take_byte(b, lastf);
        bytes_sent++;
        burst_left--;
        @(negedge clk);
    endtask

    task automatic send_file();
        int n;

        n = file_buf.size();
        for (int i = 0; i < n; i++)
            send_byte(file_buf[i], i == n - 1);
    endtask

    // hold the sender until every owed beat has come back
    task automatic wait_results_done();
        bytes_ch.valid <= 1'b0;
        while (tracker.pending_beats.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_rewrite(input logic value);
        repeat (2) @(negedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(negedge clk);
        tracker.rewrite_on = value;
        cfg_write_en <= 1'b0;
    endtask

    // random 16-byte blocks, sometimes with a misaligned start byte
    task automatic add_junk(input int blocks);
        int spot;

        for (int k = 0; k < blocks; k++)
        begin
            spot = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : -1;
            for (int i = 0; i < 16; i++)
                file_buf.push_back((i == spot) ? START_BYTE : 8'($urandom));
        end
    endtask

    // one image starting at a 16-aligned offset; an oversized segment cuts it short
    task automatic add_image(output bit cut_short);
        int          nseg;
        int          pick;
        logic [31:0] sz;
        logic [7:0]  flag;
        logic [7:0]  sum;
        logic [7:0]  d;

        cut_short = 1'b0;
        if ($urandom_range(0, 19) == 0)
            nseg = $urandom_range(4, 8);
        else if ($urandom_range(0, 4) == 0)
            nseg = 0;
        else
            nseg = $urandom_range(1, 3);
        flag = ($urandom_range(0, 9) < 6) ? 8'h00 : 8'($urandom_range(1, 255));
        sum  = SEED;

        // image header
        file_buf.push_back(START_BYTE);
        file_buf.push_back(8'(nseg));
        repeat (21) file_buf.push_back(8'($urandom));
        file_buf.push_back(flag);

        // segments
        for (int s = 0; s < nseg; s++)
        begin
            repeat (4) file_buf.push_back(8'($urandom));
            pick = $urandom_range(0, 19);
            if (pick < 2)
                sz = 32'd0;
            else if (pick == 2)
                sz = 32'h0100_0000 | 32'($urandom);
            else
                sz = $urandom_range(1, 30);
            file_buf.push_back(sz[7:0]);
            file_buf.push_back(sz[15:8]);
            file_buf.push_back(sz[23:16]);
            file_buf.push_back(sz[31:24]);
            if (pick == 2)
            begin
                // oversized segment: the file runs out inside its data
                repeat ($urandom_range(4, 40)) file_buf.push_back(8'($urandom));
                cut_short = 1'b1;
                return;
            end
            for (int j = 0; j < sz; j++)
            begin
                d   = 8'($urandom);
                sum = sum ^ d;
                file_buf.push_back(d);
            end
        end

        // padding, checksum byte, optional hash
        while (file_buf.size() % 16 != 15)
            file_buf.push_back(8'($urandom));
        file_buf.push_back(($urandom_range(0, 3) != 0) ? sum : 8'($urandom));
        if (flag != 8'h00)
            repeat (32) file_buf.push_back(8'($urandom));
    endtask

    // mostly well-formed images with random content, plus noise and damage
    task automatic build_random_file();
        int kind;
        int nimg;
        int cut_len;
        int idx;
        bit cut;

        file_buf.delete();
        cut  = 1'b0;
        kind = $urandom_range(0, 99);
        if (kind >= 70 && kind < 85)
        begin
            repeat ($urandom_range(1, 48))
            begin
                if (file_buf.size() % 16 == 0 && $urandom_range(0, 2) == 0)
                    file_buf.push_back(START_BYTE);
                else
                    file_buf.push_back(8'($urandom));
            end
            return;
        end

        if ($urandom_range(0, 2) == 0)
            add_junk($urandom_range(1, 2));
        nimg = $urandom_range(1, 3);
        for (int i = 0; i < nimg && !cut; i++)
        begin
            add_image(cut);
            if (!cut && $urandom_range(0, 3) == 0)
                add_junk(1);
        end
        if (!cut && $urandom_range(0, 3) == 0)
        begin
            cut_len = $urandom_range(1, file_buf.size());
            while (file_buf.size() > cut_len)
                void'(file_buf.pop_back());
        end
        if (kind >= 85)
        begin
            repeat ($urandom_range(1, 3))
            begin
                idx           = $urandom_range(0, file_buf.size() - 1);
                file_buf[idx] = file_buf[idx] ^ 8'($urandom_range(1, 255));
            end
        end
    endtask

    // main sequence
    initial
    begin
        int   next_switch;
        logic rw;

        tracker            = new();
        bytes_sent         = 0;
        burst_left         = 0;
        cycles             = 0;
        cfg_write_en       = 1'b0;
        cfg_write_data     = 1'b0;
        bytes_ch.valid     = 1'b0;
        bytes_ch.data_byte = 8'h00;
        bytes_ch.last_byte = 1'b0;
        rst_n              = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        write_rewrite(1'b1);

        // directed: start byte as the only byte of a file
        file_buf = '{START_BYTE};
        send_file();
        // single-byte files at the field extremes
        file_buf = '{8'h00};
        send_file();
        file_buf = '{8'hFF};
        send_file();
        // file that ends inside the image header
        file_buf = '{START_BYTE, 8'h02, 8'h7F};
        send_file();
        // start byte off the 16-byte grid is ignored
        file_buf = '{8'h10, START_BYTE, 8'h80};
        send_file();
        // new file after an end of file begins at offset zero again
        file_buf = '{START_BYTE, 8'h00};
        send_file();

        wait_results_done();
        write_rewrite(1'b0);
        rw          = 1'b0;
        next_switch = bytes_sent + 250;

        while (bytes_sent < TARGET_BYTES)
        begin
            if (bytes_sent >= next_switch)
            begin
                wait_results_done();
                rw = ~rw;
                write_rewrite(rw);
                next_switch = bytes_sent + $urandom_range(150, 350);
            end
            build_random_file();
            send_file();
        end

        wait_results_done();
        repeat (8) @(posedge clk);
        if (tracker.bad_beats == 0 && tracker.pending_beats.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* filelist.f */
src/fic_pkg.sv
src/fic_byte_if.sv
src/fic_result_if.sv
src/fic_in_stage.sv
src/fic_parser.sv
src/firmware_image_checksum_fixer_unit.sv
test/tb_firmware_image_checksum_fixer_unit.sv
